// ----- hdl/numeric_text_parser_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the numeric text parser
// Clocked property checks that compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef NUMERIC_TEXT_PARSER_TOP_MACROS_SVH
`define NUMERIC_TEXT_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checked property with the asynchronous reset masking it.
`define NTP_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("assertion failed");

// Checked property that also holds while reset is applied.
`define NTP_ASSERT_ALWAYS(lbl, clk_sig, prop) \
	lbl: assert property (@(posedge clk_sig) prop) \
		else $error("assertion failed");

`else

`define NTP_ASSERT(lbl, clk_sig, rst_n_sig, prop)
`define NTP_ASSERT_ALWAYS(lbl, clk_sig, prop)

`endif

`endif

// ----- hdl/ntp_pkg.sv -----
// ---------------------------------------------------------------------------
// ntp_pkg
// Types, character codes and helpers shared by the numeric text parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ntp_pkg;

	localparam int BASE_W  = 5;
	localparam int CNT_W   = 8;
	localparam int VALUE_W = 64;
	localparam int STAT_W  = 2;
	localparam int OUT_W   = 104;

	localparam logic [BASE_W-1:0] RESET_BASE = 5'd10;
	localparam logic [BASE_W-1:0] HEX_BASE   = 5'd16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LX    = 8'h78;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	typedef enum logic [2:0] {
		PH_FAIL = 3'd0,
		PH_LEAD = 3'd1,
		PH_SIGN = 3'd2,
		PH_ZERO = 3'd3,
		PH_PRE  = 3'd4,
		PH_DOT  = 3'd5,
		PH_POST = 3'd6,
		PH_DONE = 3'd7
	} phase_t;

	typedef enum logic [STAT_W-1:0] {
		ST_CONT = 2'd0,
		ST_DONE = 2'd1,
		ST_FAIL = 2'd2
	} status_t;

	typedef struct packed {
		phase_t               phase;
		logic [VALUE_W-1:0]   magnitude;
		logic                 negative;
		logic [CNT_W-1:0]     width;
		logic [CNT_W-1:0]     digits;
		logic [CNT_W-1:0]     precision;
		logic                 upper;
		logic                 plus;
		logic                 prefix;
		logic [BASE_W-1:0]    base;
	} parse_state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] floor_dec(input logic [CNT_W-1:0] v);
		floor_dec = (v == '0) ? v : v - 1'b1;
	endfunction

	function automatic parse_state_t fresh_state(input logic [BASE_W-1:0] b);
		parse_state_t s;
		s = '0;
		s.phase = PH_LEAD;
		s.base  = b;
		fresh_state = s;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ntp_step.sv -----
// ---------------------------------------------------------------------------
// ntp_step
// Next-state logic of the parser for one character or restart beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ntp_step (
	input  ntp_pkg::parse_state_t        cur,
	input  logic                         kind,
	input  logic [7:0]                   char_byte,
	input  logic [ntp_pkg::BASE_W-1:0]   default_base,
	output ntp_pkg::parse_state_t        nxt,
	output ntp_pkg::status_t             status
);
	import ntp_pkg::*;

	logic               is_dec;
	logic               is_lo;
	logic               is_up;
	logic               is_digit;
	logic [7:0]         dig8;
	logic [3:0]         dig;
	logic               below_base;
	logic [VALUE_W-1:0] mac;
	logic               is_ws;
	logic               do_take;
	logic               frac;
	logic               do_after_sign;

	assign is_dec   = (char_byte >= CH_0) && (char_byte <= CH_9);
	assign is_lo    = (char_byte >= CH_LA) && (char_byte <= CH_LF_HEX);
	assign is_up    = (char_byte >= CH_UA) && (char_byte <= CH_UF);
	assign is_digit = is_dec || is_lo || is_up;
	assign is_ws    = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
	                  (char_byte == CH_CR) || (char_byte == CH_LF);

	// Letters map to 10..15 by offsetting from the letter 'a' or 'A'.
	always_comb begin
		if (is_dec) begin
			dig8 = char_byte - CH_0;
		end else if (is_lo) begin
			dig8 = char_byte - CH_LA + 8'd10;
		end else begin
			dig8 = char_byte - CH_UA + 8'd10;
		end
	end
	assign dig = dig8[3:0];

	assign below_base = {1'b0, dig} < cur.base;
	assign mac        = cur.magnitude * VALUE_W'(cur.base) + VALUE_W'(dig);

	always_comb begin
		nxt           = cur;
		status        = ST_CONT;
		do_take       = 1'b0;
		frac          = 1'b0;
		do_after_sign = 1'b0;

		if (kind == KIND_RESTART) begin
			nxt = fresh_state(default_base);
		end else begin
			unique case (cur.phase)
				PH_FAIL: begin
					status = ST_FAIL;
				end
				PH_DONE: begin
					status = ST_DONE;
				end
				PH_LEAD: begin
					if (is_ws) begin
						nxt.width = sat_inc(cur.width);
					end else if (char_byte == CH_MINUS || char_byte == CH_PLUS) begin
						nxt.plus     = cur.plus | (char_byte == CH_PLUS);
						nxt.negative = (char_byte == CH_MINUS);
						nxt.width    = sat_inc(cur.width);
						nxt.phase    = PH_SIGN;
					end else begin
						do_after_sign = 1'b1;
					end
				end
				PH_SIGN: begin
					do_after_sign = 1'b1;
				end
				PH_ZERO: begin
					if (char_byte == CH_LX || char_byte == CH_UX) begin
						nxt.upper  = cur.upper | (char_byte == CH_UX);
						nxt.prefix = 1'b1;
						nxt.base   = HEX_BASE;
						nxt.width  = floor_dec(cur.width);
						nxt.digits = floor_dec(cur.digits);
						nxt.phase  = PH_PRE;
					end else begin
						do_take = 1'b1;
					end
				end
				PH_PRE: begin
					do_take = 1'b1;
				end
				PH_DOT, PH_POST: begin
					do_take = 1'b1;
					frac    = 1'b1;
				end
				default: begin
					status = ST_FAIL;
				end
			endcase

			// A leading zero is held back so that an x may still turn it into a prefix.
			if (do_after_sign) begin
				if (char_byte == CH_0) begin
					nxt.width  = sat_inc(cur.width);
					nxt.digits = sat_inc(cur.digits);
					nxt.phase  = PH_ZERO;
				end else begin
					do_take = 1'b1;
				end
			end

			if (do_take) begin
				if (is_digit) begin
					if (!below_base) begin
						nxt.phase = PH_FAIL;
						status    = ST_FAIL;
					end else begin
						nxt.upper     = cur.upper | is_up;
						nxt.width     = sat_inc(cur.width);
						nxt.digits    = sat_inc(cur.digits);
						nxt.precision = frac ? sat_inc(cur.precision) : cur.precision;
						nxt.magnitude = mac;
						nxt.phase     = frac ? PH_POST : PH_PRE;
					end
				end else if (!frac && char_byte == CH_DOT) begin
					nxt.width = sat_inc(cur.width);
					nxt.phase = PH_DOT;
				end else begin
					nxt.phase = PH_DONE;
					status    = ST_DONE;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/numeric_text_parser_top.sv -----
// ---------------------------------------------------------------------------
// numeric_text_parser_top
// Streaming parser that turns text bytes into a number and format fields.
// ---------------------------------------------------------------------------
// A beat is held in the input register, then parsed into the result register,
// which presents it on the master side. Throughput: one beat per cycle while
// m_tready does not stall the result, set by the single state update path.
// Reset: arst_n clears all control state at once; the parser restarts with
// base 10 and the default base register returns to 10.
`timescale 1ns / 1ps
`default_nettype none
`include "numeric_text_parser_top_macros.svh"

module numeric_text_parser_top (
	input  logic                          clk,
	input  logic                          arst_n,

	// Input stream. tdata: char_byte[7:0]. tuser: kind[0].
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tuser,

	// Result stream. tdata from bit 0 up: status[1:0], value[65:2],
	// negative[66], width[74:67], digit_count[82:75], precision[90:83],
	// flag_upper[91], flag_plus[92], flag_prefix[93], base_used[98:94],
	// zero fill[103:99].
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ntp_pkg::OUT_W-1:0]     m_tdata,

	// Default base register write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ntp_pkg::BASE_W-1:0]    cfg_data
);
	import ntp_pkg::*;

	// Input register: one beat waits here for its turn at the state update.
	logic                 v_s1;
	logic                 kind_s1;
	logic [7:0]           char_s1;

	// Parser state and the default base register.
	parse_state_t         st_q;
	parse_state_t         st_next;
	status_t              status_next;
	logic [BASE_W-1:0]    def_base_q;

	// Result register.
	logic                 m_valid_q;
	logic [OUT_W-1:0]     m_data_q;

	logic                 adv;

	// A beat moves from the input register into the result register when the
	// result register is empty or its current beat is being taken. The input
	// register refills in the same cycle, so a steady stream runs at full rate while m_tready is high.
	assign adv      = v_s1 && (!m_valid_q || m_tready);
	assign s_tready = !v_s1 || adv;

	// The register write is always taken; the host must write only while idle, and the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_base_q <= RESET_BASE;
		end else if (cfg_valid) begin
			def_base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			char_s1 <= s_tdata;
		end
	end

	ntp_step u_step (
		.cur          (st_q),
		.kind         (kind_s1),
		.char_byte    (char_s1),
		.default_base (def_base_q),
		.nxt          (st_next),
		.status       (status_next)
	);

	// The parser state advances exactly once per beat, together with the
	// result register, so the reported fields always match the state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fresh_state(RESET_BASE);
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {5'b0, st_next.base, st_next.prefix, st_next.plus,
			             st_next.upper, st_next.precision, st_next.digits,
			             st_next.width, st_next.negative, st_next.magnitude,
			             status_next};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Input side stalls only when a beat is parked and the result is blocked.
	`NTP_ASSERT(a_ready_only_when_blocked, clk, arst_n, !s_tready |-> (v_s1 && m_valid_q && !m_tready))
	// A finished or failed parse keeps its state until a restart.
	`NTP_ASSERT(a_terminal_holds, clk, arst_n, (adv && kind_s1 == KIND_CHAR && (st_q.phase == PH_FAIL || st_q.phase == PH_DONE)) |=> $stable(st_q))
	// A restart clears the counters and loads the register base.
	`NTP_ASSERT(a_restart_loads, clk, arst_n, (adv && kind_s1 == KIND_RESTART) |=> (st_q.width == '0 && st_q.base == $past(def_base_q)))
	// Fraction digits are a subset of all digits.
	`NTP_ASSERT(a_precision_le_digits, clk, arst_n, st_q.precision <= st_q.digits)

endmodule

`default_nettype wire
